>>> hdl/seven_segment_two_wire_display_driver_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the seven-segment two-wire display driver
// Concurrent checks sampled on clk, held off during rst.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_TWO_WIRE_DISPLAY_DRIVER_MACROS_SVH
`define SEVEN_SEGMENT_TWO_WIRE_DISPLAY_DRIVER_MACROS_SVH

// Same-cycle implication.
`define SSDD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSDD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ssdd_pkg.sv
// ----------------------------------------------------------------------------
// ssdd_pkg
// Shared types, constants and segment encoding for the display driver.
// ----------------------------------------------------------------------------
package ssdd_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int DIGIT_IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int BYTE_CNT_W  = $clog2(DIGIT_COUNT + 3);
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 4;

  localparam logic [7:0] CMD_DATA_WRITE = 8'h40;
  localparam logic [7:0] CMD_ADDR_FIRST = 8'hC0;
  localparam logic [7:0] CMD_CTRL_BASE  = 8'h87;
  localparam logic [7:0] SEG_POINT      = 8'h80;
  localparam logic [6:0] VALUE_BLANK    = 7'h7f;

  localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POINT      = 1'b1;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_SHOW  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef logic [7:0] seg_t;
  typedef seg_t [DIGIT_COUNT-1:0] digits_t;

  typedef struct packed {
    logic clk;
    logic dat;
    logic drive;
  } pins_t;

  localparam seg_t SEG_TABLE [16] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07,
    8'h7f, 8'h6f, 8'h77, 8'h7c, 8'h39, 8'h5e, 8'h79, 8'h71
  };

  // Anything outside 0..15 (including the blank code) lights no digit segment; only the point may be set.
  function automatic seg_t encode_digit(logic [6:0] value, logic point);
    seg_t seg;
    seg = (value < 7'd16) ? SEG_TABLE[value[3:0]] : 8'h00;
    return seg | (point ? SEG_POINT : 8'h00);
  endfunction

endpackage

>>> hdl/ssdd_seq.sv
// ----------------------------------------------------------------------------
// ssdd_seq
// Pin sequencer: one pin action per step for the three-frame link sequence.
// ----------------------------------------------------------------------------
module ssdd_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  ssdd_pkg::kind_t       cmd,
  input  logic                  ack_line,
  input  ssdd_pkg::digits_t     digits,
  input  logic [3:0]            brightness,
  output ssdd_pkg::pins_t       pins,
  output logic                  busy
);

  localparam int BW = ssdd_pkg::BYTE_CNT_W;
  localparam logic [BW-1:0] LAST_DIGIT_BYTE = BW'(1 + ssdd_pkg::DIGIT_COUNT);
  localparam logic [BW-1:0] CTRL_BYTE       = BW'(2 + ssdd_pkg::DIGIT_COUNT);

  typedef enum logic [4:0] {
    PH_IDLE, PH_S1, PH_S2, PH_S3,
    PH_B1, PH_B2, PH_B3,
    PH_A1, PH_A2, PH_A3, PH_A4, PH_A5, PH_A6,
    PH_T1, PH_T2, PH_T3, PH_T4
  } phase_t;

  phase_t          phase, phase_next, phase_eff;
  logic [BW-1:0]   byte_cnt, byte_cnt_next, byte_eff;
  logic [2:0]      bit_cnt, bit_cnt_next, bit_eff;
  ssdd_pkg::seg_t  shift_byte, shift_byte_next;
  logic            clearing, clearing_next;
  ssdd_pkg::pins_t pins_next;
  logic            start;

  function automatic ssdd_pkg::seg_t frame_byte(logic [BW-1:0] b, logic clr,
                                                ssdd_pkg::digits_t d,
                                                logic [3:0] bright);
    logic [BW-1:0] off;
    off = b - BW'(2);
    if (b == BW'(0)) return ssdd_pkg::CMD_DATA_WRITE;
    if (b == BW'(1)) return ssdd_pkg::CMD_ADDR_FIRST;
    if (b < CTRL_BYTE) return clr ? 8'h00 : d[off[ssdd_pkg::DIGIT_IDX_W-1:0]];
    return ssdd_pkg::CMD_CTRL_BASE + {4'b0000, bright};
  endfunction

  assign start = (cmd == ssdd_pkg::KIND_SHOW || cmd == ssdd_pkg::KIND_CLEAR) &&
                 phase == PH_IDLE;

  always_comb begin
    phase_eff       = start ? PH_S1 : phase;
    byte_eff        = start ? '0 : byte_cnt;
    bit_eff         = start ? 3'd0 : bit_cnt;
    clearing_next   = start ? (cmd == ssdd_pkg::KIND_CLEAR) : clearing;
    phase_next      = phase_eff;
    byte_cnt_next   = byte_eff;
    bit_cnt_next    = bit_eff;
    shift_byte_next = shift_byte;
    pins_next       = pins;
    unique case (phase_eff)
      PH_IDLE: ;
      PH_S1: begin pins_next.clk = 1'b1; phase_next = PH_S2; end
      PH_S2: begin pins_next.dat = 1'b1; phase_next = PH_S3; end
      PH_S3: begin
        pins_next.dat   = 1'b0;
        shift_byte_next = frame_byte(byte_eff, clearing_next, digits, brightness);
        bit_cnt_next    = 3'd0;
        phase_next      = PH_B1;
      end
      PH_B1: begin pins_next.clk = 1'b0; phase_next = PH_B2; end
      PH_B2: begin
        pins_next.dat   = shift_byte[0];
        shift_byte_next = {1'b0, shift_byte[7:1]};
        phase_next      = PH_B3;
      end
      PH_B3: begin
        pins_next.clk = 1'b1;
        if (bit_eff == 3'd7) begin
          bit_cnt_next = 3'd0;
          phase_next   = PH_A1;
        end else begin
          bit_cnt_next = bit_eff + 3'd1;
          phase_next   = PH_B1;
        end
      end
      PH_A1: begin pins_next.clk = 1'b0; phase_next = PH_A2; end
      PH_A2: begin pins_next.drive = 1'b0; phase_next = PH_A3; end
      // hold until the display pulls data low; no timeout
      PH_A3: if (!ack_line) phase_next = PH_A4;
      PH_A4: begin pins_next.drive = 1'b1; phase_next = PH_A5; end
      PH_A5: begin pins_next.clk = 1'b1; phase_next = PH_A6; end
      PH_A6: begin
        pins_next.clk = 1'b0;
        if (byte_eff == BW'(0) || byte_eff >= LAST_DIGIT_BYTE) begin
          phase_next = PH_T1;
        end else begin
          byte_cnt_next   = byte_eff + BW'(1);
          shift_byte_next = frame_byte(byte_cnt_next, clearing_next, digits, brightness);
          bit_cnt_next    = 3'd0;
          phase_next      = PH_B1;
        end
      end
      PH_T1: begin pins_next.clk = 1'b0; phase_next = PH_T2; end
      PH_T2: begin pins_next.dat = 1'b0; phase_next = PH_T3; end
      PH_T3: begin pins_next.clk = 1'b1; phase_next = PH_T4; end
      PH_T4: begin
        pins_next.dat = 1'b1;
        if (byte_eff >= CTRL_BYTE) begin
          byte_cnt_next = '0;
          phase_next    = PH_IDLE;
        end else begin
          byte_cnt_next = byte_eff + BW'(1);
          phase_next    = PH_S1;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      byte_cnt   <= '0;
      bit_cnt    <= 3'd0;
      shift_byte <= 8'h00;
      clearing   <= 1'b0;
      pins       <= '{clk: 1'b1, dat: 1'b1, drive: 1'b1};
    end else if (step) begin
      phase      <= phase_next;
      byte_cnt   <= byte_cnt_next;
      bit_cnt    <= bit_cnt_next;
      shift_byte <= shift_byte_next;
      clearing   <= clearing_next;
      pins       <= pins_next;
    end
  end

  assign busy = (phase != PH_IDLE);

endmodule

>>> hdl/seven_segment_two_wire_display_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_two_wire_display_driver
// Four-digit seven-segment display driver over a bit-banged clock/data link.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transaction:
//   tick, write digit, show digits or clear display, plus the sampled data
//   pin level. Every transaction advances the pin sequencer by one action.
//   Output channel (out_valid/out_ready) returns one result per input
//   transaction: the clock and data pin levels, the data drive enable and
//   the busy flag as they stand after that step.
//   The result is registered at the accepting edge and shown the next
//   cycle. Throughput is one transaction per cycle; the output register
//   is the only stage, so in_ready falls only while a result sits
//   unaccepted (out_valid high, out_ready low).
//   Configuration (cfg_valid/cfg_ready) is always ready; index 0 sets
//   brightness, index 1 the decimal point enable.
//   Reset clears the digit registers, returns the sequencer to idle with
//   clock and data high and driven, sets brightness to 1 and point off.
//   A show or clear runs until the display acknowledges each byte.
// ----------------------------------------------------------------------------
`include "seven_segment_two_wire_display_driver_macros.svh"

module seven_segment_two_wire_display_driver (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       kind,
  input  logic [2:0]                       digit_index,
  input  logic [6:0]                       digit_value,
  input  logic                             data_line_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             clock_line_out,
  output logic                             data_line_out,
  output logic                             data_drive_enable,
  output logic                             busy_res,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ssdd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ssdd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic              accept;
  ssdd_pkg::kind_t   cmd;
  ssdd_pkg::digits_t digits, digits_next;
  logic [3:0]        brightness;
  logic              point_enable;
  ssdd_pkg::pins_t   pins;
  logic              busy;

  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cmd       = ssdd_pkg::kind_t'(kind);

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness   <= 4'd1;
      point_enable <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ssdd_pkg::CFG_BRIGHTNESS: brightness   <= cfg_data[3:0];
        ssdd_pkg::CFG_POINT:      point_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Digit write lands first so a byte loaded in the same step sees it.
  always_comb begin
    digits_next = digits;
    for (int i = 0; i < ssdd_pkg::DIGIT_COUNT; i++) begin
      if (cmd == ssdd_pkg::KIND_WRITE && {1'b0, digit_index} == 4'(i + 1)) begin
        digits_next[i] = ssdd_pkg::encode_digit(digit_value, point_enable);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digits <= '0;
    end else if (accept) begin
      digits <= digits_next;
    end
  end

  ssdd_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .cmd        (cmd),
    .ack_line   (data_line_in),
    .digits     (digits_next),
    .brightness (brightness),
    .pins       (pins),
    .busy       (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign clock_line_out    = pins.clk;
  assign data_line_out     = pins.drive & pins.dat;
  assign data_drive_enable = pins.drive;
  assign busy_res          = busy;

  `SSDD_ASSERT_NEXT(a_result_follows, accept, out_valid, "accepted transaction gave no result")
  `SSDD_ASSERT_NOW(a_release_only_busy, !data_drive_enable, busy_res, "data released while idle")
  `SSDD_ASSERT_NOW(a_idle_pins_high, !busy_res,
                   clock_line_out && data_line_out && data_drive_enable,
                   "idle link not parked high")

endmodule

>>> tb/display_link_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// display_link_checker
// Watches the command, result and register channels of the display driver.
// Keeps its own copy of the digit registers and the pin sequencer, works out
// the pin levels after every accepted command and compares each accepted
// result against the oldest one still owed.
// ----------------------------------------------------------------------------
module display_link_checker
  import ssdd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [1:0]             kind,
  input  logic [2:0]             digit_index,
  input  logic [6:0]             digit_value,
  input  logic                   data_line_in,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   clock_line_out,
  input  logic                   data_line_out,
  input  logic                   data_drive_enable,
  input  logic                   busy_res,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending,
  output logic                   seq_busy
);

  typedef enum logic [4:0] {
    LINK_IDLE,
    START_CLK,
    START_DAT_HI,
    START_DAT_LO,
    BIT_CLK_LO,
    BIT_DATA,
    BIT_CLK_HI,
    ACK_CLK_LO,
    ACK_RELEASE,
    ACK_WAIT,
    ACK_DRIVE,
    ACK_CLK_HI,
    ACK_CLK_END,
    STOP_CLK_LO,
    STOP_DAT_LO,
    STOP_CLK_HI,
    STOP_DAT_HI
  } link_phase_t;

  typedef struct packed {
    logic clk_lvl;
    logic dat_lvl;
    logic drv_lvl;
    logic busy;
  } pin_result_t;

  seg_t        seg_regs [DIGIT_COUNT];
  link_phase_t link_phase;
  int unsigned byte_idx;
  int unsigned bit_idx;
  seg_t        shift_reg;
  logic        clearing;
  logic        clk_lvl;
  logic        dat_lvl;
  logic        drv_lvl;
  logic [3:0]  bright;
  logic        point_on;
  pin_result_t pin_q [$];

  assign seq_busy = (link_phase != LINK_IDLE);

  function automatic seg_t glyph(logic [6:0] v);
    seg_t s;
    s = (v < 7'd16) ? SEG_TABLE[v[3:0]] : 8'h00;
    if (point_on) s = s | SEG_POINT;
    return s;
  endfunction

  // Byte b of the whole show/clear sequence, counted across all three frames.
  function automatic seg_t frame_byte(int unsigned b);
    if (b == 0) return CMD_DATA_WRITE;
    if (b == 1) return CMD_ADDR_FIRST;
    if (b < 2 + DIGIT_COUNT) return clearing ? 8'h00 : seg_regs[b - 2];
    return CMD_CTRL_BASE + {4'h0, bright};
  endfunction

  function automatic void advance_link(logic ack_bit);
    case (link_phase)
      START_CLK: begin
        clk_lvl = 1'b1;
        link_phase = START_DAT_HI;
      end
      START_DAT_HI: begin
        dat_lvl = 1'b1;
        link_phase = START_DAT_LO;
      end
      START_DAT_LO: begin
        dat_lvl = 1'b0;
        shift_reg = frame_byte(byte_idx);
        bit_idx = 0;
        link_phase = BIT_CLK_LO;
      end
      BIT_CLK_LO: begin
        clk_lvl = 1'b0;
        link_phase = BIT_DATA;
      end
      BIT_DATA: begin
        dat_lvl = shift_reg[0];
        shift_reg = shift_reg >> 1;
        link_phase = BIT_CLK_HI;
      end
      BIT_CLK_HI: begin
        clk_lvl = 1'b1;
        if (bit_idx >= 7) begin
          bit_idx = 0;
          link_phase = ACK_CLK_LO;
        end else begin
          bit_idx++;
          link_phase = BIT_CLK_LO;
        end
      end
      ACK_CLK_LO: begin
        clk_lvl = 1'b0;
        link_phase = ACK_RELEASE;
      end
      ACK_RELEASE: begin
        drv_lvl = 1'b0;
        link_phase = ACK_WAIT;
      end
      // hold here until the display pulls data low
      ACK_WAIT: begin
        if (!ack_bit) link_phase = ACK_DRIVE;
      end
      ACK_DRIVE: begin
        drv_lvl = 1'b1;
        link_phase = ACK_CLK_HI;
      end
      ACK_CLK_HI: begin
        clk_lvl = 1'b1;
        link_phase = ACK_CLK_END;
      end
      // the address frame carries the digit bytes; other frames hold one byte
      ACK_CLK_END: begin
        clk_lvl = 1'b0;
        if (byte_idx == 0 || byte_idx >= DIGIT_COUNT + 1) begin
          link_phase = STOP_CLK_LO;
        end else begin
          byte_idx++;
          shift_reg = frame_byte(byte_idx);
          bit_idx = 0;
          link_phase = BIT_CLK_LO;
        end
      end
      STOP_CLK_LO: begin
        clk_lvl = 1'b0;
        link_phase = STOP_DAT_LO;
      end
      STOP_DAT_LO: begin
        dat_lvl = 1'b0;
        link_phase = STOP_CLK_HI;
      end
      STOP_CLK_HI: begin
        clk_lvl = 1'b1;
        link_phase = STOP_DAT_HI;
      end
      STOP_DAT_HI: begin
        dat_lvl = 1'b1;
        if (byte_idx >= DIGIT_COUNT + 2) begin
          byte_idx = 0;
          link_phase = LINK_IDLE;
        end else begin
          byte_idx++;
          link_phase = START_CLK;
        end
      end
      default: link_phase = LINK_IDLE;
    endcase
  endfunction

  function automatic pin_result_t predict_pins(kind_t k, logic [2:0] idx, logic [6:0] v,
                                               logic ack_bit);
    pin_result_t r;
    if (k == KIND_WRITE && idx >= 1 && idx <= DIGIT_COUNT) seg_regs[idx - 1] = glyph(v);
    if ((k == KIND_SHOW || k == KIND_CLEAR) && link_phase == LINK_IDLE) begin
      clearing = (k == KIND_CLEAR);
      byte_idx = 0;
      bit_idx = 0;
      link_phase = START_CLK;
    end
    if (link_phase != LINK_IDLE) advance_link(ack_bit);
    r.clk_lvl = clk_lvl;
    r.dat_lvl = drv_lvl ? dat_lvl : 1'b0;
    r.drv_lvl = drv_lvl;
    r.busy = (link_phase != LINK_IDLE);
    return r;
  endfunction

  function automatic void check_bit(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, actual %0b", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    pin_result_t want;
    if (rst) begin
      foreach (seg_regs[i]) seg_regs[i] = 8'h00;
      link_phase = LINK_IDLE;
      byte_idx = 0;
      bit_idx = 0;
      shift_reg = 8'h00;
      clearing = 1'b0;
      clk_lvl = 1'b1;
      dat_lvl = 1'b1;
      drv_lvl = 1'b1;
      bright = 4'd1;
      point_on = 1'b0;
      pin_q.delete();
      fail_count = 0;
    end else begin
      // check the result first: it belongs to an earlier transaction
      if (out_valid && out_ready) begin
        if (pin_q.size() == 0) begin
          $error("result transaction with no expected result waiting");
          fail_count++;
        end else begin
          want = pin_q.pop_front();
          check_bit("clock_line_out", want.clk_lvl, clock_line_out);
          check_bit("data_line_out", want.dat_lvl, data_line_out);
          check_bit("data_drive_enable", want.drv_lvl, data_drive_enable);
          check_bit("busy_res", want.busy, busy_res);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BRIGHTNESS) bright = cfg_data;
        else if (cfg_index == CFG_POINT) point_on = cfg_data[0];
      end
      if (in_valid && in_ready)
        pin_q.push_back(predict_pins(kind_t'(kind), digit_index, digit_value, data_line_in));
    end
    pending = pin_q.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives digit writes, show and clear commands and acknowledge levels into
// the display driver over several brightness and decimal point settings,
// with random gaps on the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;
  import ssdd_pkg::*;

  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int STALL_LIMIT     = 1000;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             kind;
  logic [2:0]             digit_index;
  logic [6:0]             digit_value;
  logic                   data_line_in;
  logic                   out_valid;
  logic                   out_ready;
  logic                   clock_line_out;
  logic                   data_line_out;
  logic                   data_drive_enable;
  logic                   busy_res;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int   fail_count;
  int   pending;
  logic seq_busy;
  logic in_gaps;
  logic out_gaps;
  int   idle_cycles;

  seven_segment_two_wire_display_driver u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .kind              (kind),
    .digit_index       (digit_index),
    .digit_value       (digit_value),
    .data_line_in      (data_line_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .clock_line_out    (clock_line_out),
    .data_line_out     (data_line_out),
    .data_drive_enable (data_drive_enable),
    .busy_res          (busy_res),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  display_link_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .kind              (kind),
    .digit_index       (digit_index),
    .digit_value       (digit_value),
    .data_line_in      (data_line_in),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .clock_line_out    (clock_line_out),
    .data_line_out     (data_line_out),
    .data_drive_enable (data_drive_enable),
    .busy_res          (busy_res),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .pending           (pending),
    .seq_busy          (seq_busy)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort when no channel has moved a transaction for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: when out_gaps is set, stall for a random count before taking each result.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = out_gaps ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // Leaves valid high on return so back-to-back transactions need no drop.
  task automatic send_item(kind_t k, int idx, int v, logic ack_bit);
    int gap;
    gap = in_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    digit_index  <= idx[2:0];
    digit_value  <= v[6:0];
    data_line_in <= ack_bit;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    int   pick;
    int   idx;
    int   v;
    kind_t k;
    logic ack_bit;
    pick = $urandom_range(0, 99);
    if (pick < 78) k = KIND_TICK;
    else if (pick < 90) k = KIND_WRITE;
    else if (pick < 95) k = KIND_SHOW;
    else k = KIND_CLEAR;
    idx = ($urandom_range(0, 99) < 70) ? $urandom_range(1, DIGIT_COUNT) : $urandom_range(0, 7);
    pick = $urandom_range(0, 99);
    if (pick < 60) v = $urandom_range(0, 15);
    else if (pick < 75) v = VALUE_BLANK;
    else v = $urandom_range(0, 127);
    // mostly answer the acknowledge, sometimes make the link wait
    ack_bit = ($urandom_range(0, 99) < 20);
    send_item(k, idx, v, ack_bit);
  endtask

  task automatic run_directed();
    send_item(KIND_WRITE, 1, 0, 1'b0);
    send_item(KIND_WRITE, 2, 15, 1'b1);
    send_item(KIND_WRITE, 3, VALUE_BLANK, 1'b0);
    send_item(KIND_WRITE, 4, 16, 1'b1);
    send_item(KIND_WRITE, 4, 126, 1'b0);
    send_item(KIND_WRITE, 0, 5, 1'b0);
    send_item(KIND_WRITE, 5, 3, 1'b1);
    send_item(KIND_WRITE, 7, 8, 1'b0);
    send_item(KIND_TICK, 7, 127, 1'b1);
    send_item(KIND_SHOW, 0, 0, 1'b1);
    send_item(KIND_TICK, 0, 0, 1'b1);
    send_item(KIND_WRITE, 1, 9, 1'b1);
    send_item(KIND_SHOW, 0, 0, 1'b0);
    send_item(KIND_CLEAR, 0, 0, 1'b0);
    send_item(KIND_WRITE, 3, 10, 1'b0);
    send_item(KIND_WRITE, 2, 7, 1'b0);
    send_item(KIND_TICK, 0, 0, 1'b0);
    send_item(KIND_TICK, 0, 0, 1'b1);
    send_item(KIND_TICK, 0, 0, 1'b0);
  endtask

  // Finish any running sequence and drain all results before touching registers.
  task automatic settle();
    while (seq_busy) send_item(KIND_TICK, 0, 0, 1'b0);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [3:0] bright_plan [PHASES];
    logic       point_plan  [PHASES];
    int         n;
    bright_plan = '{4'd8, 4'd0, 4'd15, 4'($urandom_range(0, 15)), 4'd1,
                    4'($urandom_range(0, 8))};
    point_plan  = '{1'b1, 1'b0, 1'b1, 1'($urandom_range(0, 1)), 1'b0,
                    1'($urandom_range(0, 1))};
    rst          = 1'b1;
    in_valid     = 1'b0;
    kind         = KIND_TICK;
    digit_index  = '0;
    digit_value  = '0;
    data_line_in = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_BRIGHTNESS;
    cfg_data     = '0;
    in_gaps      = 1'b1;
    out_gaps     = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      in_gaps  = (p % 3 != 1);
      out_gaps = (p % 3 != 2);
      write_reg(CFG_BRIGHTNESS, bright_plan[p]);
      write_reg(CFG_POINT, {3'b000, point_plan[p]});
      cfg_valid <= 1'b0;
      if (p == 0) run_directed();
      for (n = 0; n < ITEMS_PER_PHASE; n++) send_random();
      settle();
    end
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
